// File: rtl/pid_pkg.sv
// Package for the PID controller: constants, register indexes and sequencer states.
package pid_pkg;

  localparam int unsigned QBits     = 32;
  localparam int unsigned DtBits    = 16;
  localparam int unsigned DriveBits = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned DivSteps  = 48;

  localparam logic [CfgIdxW-1:0] RegGainP = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFloor = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCeil  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBand  = 3'd5;

  typedef enum logic [3:0] {
    StIdle, StErr, StDiv, StMulP, StMulD, StMulI1, StHold, StMulE, StInt,
    StMulI2, StFin, StOut
  } state_e;

  // Saturate a 65-bit signed value to signed 32 bit.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: rtl/pid_deadband_antiwindup.sv
// Top level of the PID controller with deadband, derivative on measurement and anti-windup.
//
//  channel | dir | handshake            | content
//  s_axis  | in  | tvalid/tready        | setpoint, sample, step_time
//  m_axis  | out | tvalid/tready        | drive, clamped, integrator_held
//  cfg     | in  | cfg_we_i             | register index and data
//
// An active item, once accepted, forms the error and loads the divider, runs the
// bit-serial restoring divide of the measurement difference by the time step, makes
// five passes through the one shared multiplier (P, D, I, increment, I again) plus
// hold test and clamps, and then loads the output register. An idle item (setpoint
// at or below zero) goes from forming the error straight to the output load.
// Reset clears the state, integrator, last sample, config registers and output valid.
// The input is ready whenever no item is in work, even while a result waits; the
// last step of an item holds until the previous result has been taken.
module pid_deadband_antiwindup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] setpoint, [63:32] sample, [79:64] step_time
  input  logic [79:0]                 s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] drive
  output logic [15:0]                 m_axis_tdata,
  // [0] clamped, [1] integrator_held
  output logic [1:0]                  m_axis_tuser,
  input  logic                        cfg_we_i,
  input  logic [pid_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i
);
  pid_pkg::state_e state_q, state_d;

  logic [31:0] gp_q, gi_q, gd_q, band_q;
  logic signed [31:0] floor_q, ceil_q, integ_q, last_q;
  logic signed [31:0] sp_q, meas_q, err_q, dmeas_q;
  logic [15:0] dt_q;
  logic signed [48:0] pterm_q, dterm_q, iterm_q;
  logic held_q;
  logic [47:0] num_q, quo_q;
  logic [16:0] rem_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic        ovalid_q;
  logic [15:0] drive_q;
  logic        clip_q, oheld_q;

  logic [31:0]        mgain;
  logic signed [32:0] mop;
  logic signed [48:0] mprod;

  pid_mul u_mul (.clk_i(clk_i), .gain_i(mgain), .opnd_i(mop), .prod_o(mprod));

  // Select the multiplier operands for the current step.
  always_comb begin
    mgain = gp_q;
    mop   = {err_q[31], err_q};
    unique case (state_q)
      pid_pkg::StMulD:  begin mgain = gd_q; mop = {dmeas_q[31], dmeas_q}; end
      pid_pkg::StMulI1,
      pid_pkg::StMulI2: begin mgain = gi_q; mop = {integ_q[31], integ_q}; end
      pid_pkg::StMulE:  begin mgain = {16'd0, dt_q}; mop = {err_q[31], err_q}; end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == pid_pkg::StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = drive_q;
  assign m_axis_tuser  = {oheld_q, clip_q};

  logic in_go;
  logic out_free;
  assign in_go    = s_axis_tvalid && s_axis_tready;
  // Output register is free, or its item leaves at this edge.
  assign out_free = !ovalid_q || m_axis_tready;

  // Error with deadband, magnitude of measurement difference.
  logic signed [31:0] err_raw;
  logic [31:0]        aerr;
  logic signed [32:0] diff;
  logic [32:0]        adiff;
  assign err_raw = pid_pkg::sat32(65'(sp_q) - 65'(meas_q));
  assign aerr    = err_raw[31] ? 32'(-err_raw) : err_raw;
  assign diff    = 33'(meas_q) - 33'(last_q);
  assign adiff   = diff[32] ? 33'(-diff) : diff;

  // One restoring divide step.
  logic [16:0] rsh;
  logic        rge;
  assign rsh = {rem_q[15:0], num_q[47]};
  assign rge = rsh >= {1'b0, dt_q};

  // Tentative and final sums, saturation test, integrator update.
  logic signed [50:0] tsum;
  logic        hold_c;
  logic signed [49:0] acc;
  logic signed [31:0] acc_c;
  logic signed [33:0] fsat;
  assign tsum   = 51'(pterm_q) + 51'(iterm_q) - 51'(dterm_q);
  assign hold_c = (tsum >= 51'sd65536 && !err_q[31] && err_q != 0) ||
                  (tsum <= -51'sd65536 && err_q[31]);
  assign acc    = 50'(integ_q) + 50'(mprod);
  always_comb begin
    acc_c = acc[31:0];
    if (acc > 50'(ceil_q)) acc_c = ceil_q;
    if ((acc > 50'(ceil_q) ? 50'(ceil_q) : acc) < 50'(floor_q)) acc_c = floor_q;
  end
  assign fsat = (tsum > 51'sd65536) ? 34'sd65536 :
                (tsum < -51'sd65536) ? -34'sd65536 : tsum[33:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pid_pkg::StIdle:  if (in_go) state_d = pid_pkg::StErr;
      pid_pkg::StErr:   state_d = (sp_q <= 0) ? pid_pkg::StOut : pid_pkg::StDiv;
      pid_pkg::StDiv:   if (cnt_q == 6'(pid_pkg::DivSteps - 1)) state_d = pid_pkg::StMulP;
      pid_pkg::StMulP:  state_d = pid_pkg::StMulD;
      pid_pkg::StMulD:  state_d = pid_pkg::StMulI1;
      pid_pkg::StMulI1: state_d = pid_pkg::StHold;
      pid_pkg::StHold:  state_d = pid_pkg::StMulE;
      pid_pkg::StMulE:  state_d = pid_pkg::StInt;
      pid_pkg::StInt:   state_d = pid_pkg::StMulI2;
      pid_pkg::StMulI2: state_d = pid_pkg::StFin;
      pid_pkg::StFin:   state_d = pid_pkg::StOut;
      pid_pkg::StOut:   if (out_free) state_d = pid_pkg::StIdle;
      default:          state_d = pid_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pid_pkg::StIdle;
      gp_q <= '0; gi_q <= '0; gd_q <= '0; band_q <= '0;
      floor_q <= '0; ceil_q <= '0; integ_q <= '0; last_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pid_pkg::RegGainP: gp_q    <= cfg_data_i;
          pid_pkg::RegGainI: gi_q    <= cfg_data_i;
          pid_pkg::RegGainD: gd_q    <= cfg_data_i;
          pid_pkg::RegFloor: floor_q <= cfg_data_i;
          pid_pkg::RegCeil:  ceil_q  <= cfg_data_i;
          pid_pkg::RegBand:  band_q  <= {1'b0, cfg_data_i[30:0]};
          default: ;
        endcase
      end
      // Load a new result once the register is free, else drop the taken one.
      if (state_q == pid_pkg::StOut && out_free) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      // Idle item: clear integrator, store sample.
      if (state_q == pid_pkg::StErr && sp_q <= 0) begin
        integ_q <= '0;
        last_q  <= meas_q;
      end
      if (state_q == pid_pkg::StInt && !held_q) integ_q <= acc_c;
      if (state_q == pid_pkg::StFin) last_q <= meas_q;
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_go) begin
      sp_q   <= s_axis_tdata[31:0];
      meas_q <= s_axis_tdata[63:32];
      dt_q   <= (s_axis_tdata[79:64] == '0) ? 16'd1 : s_axis_tdata[79:64];
    end
    unique case (state_q)
      pid_pkg::StErr: begin
        err_q   <= (aerr <= band_q) ? '0 : err_raw;
        num_q   <= {adiff[31:0], 16'd0};
        neg_q   <= diff[32];
        rem_q   <= '0;
        cnt_q   <= '0;
      end
      pid_pkg::StDiv: begin
        rem_q <= rge ? 17'(rsh - {1'b0, dt_q}) : rsh;
        quo_q <= {quo_q[46:0], rge};
        num_q <= {num_q[46:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
      end
      pid_pkg::StMulP: begin
        if (!neg_q) dmeas_q <= (quo_q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_q[31:0];
        else dmeas_q <= (quo_q > 48'h80000000) ? 32'sh80000000 : 32'(-quo_q[31:0]);
      end
      pid_pkg::StMulD:  pterm_q <= mprod;
      pid_pkg::StMulI1: dterm_q <= mprod;
      pid_pkg::StHold:  iterm_q <= mprod;
      pid_pkg::StMulE:  held_q  <= hold_c;
      pid_pkg::StFin: begin
        iterm_q <= mprod;
      end
      pid_pkg::StOut: if (out_free) begin
        if (sp_q > 0) begin
          drive_q <= fsat[17:2];
          clip_q  <= (tsum > 51'sd65536) || (tsum < -51'sd65536);
          oheld_q <= held_q;
        end else begin
          drive_q <= '0; clip_q <= 1'b0; oheld_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/pid_mul.sv
// Shared multiplier: unsigned 32-bit gain times signed 33-bit operand, floor shift by 16.
module pid_mul (
  input  logic               clk_i,
  input  logic [31:0]        gain_i,
  input  logic signed [32:0] opnd_i,
  output logic signed [48:0] prod_o
);
  logic signed [65:0] full;
  assign full = $signed({1'b0, gain_i}) * opnd_i;
  // Arithmetic shift right is floor division by 2^16.
  always_ff @(posedge clk_i) begin
    prod_o <= full[64:16];
  end
endmodule

// File: verif/pid_deadband_antiwindup_tb.sv
// Self-checking testbench for the PID controller with deadband and anti-windup.
module pid_deadband_antiwindup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned RandItems = 1450;

  typedef struct packed {
    logic [15:0] step_time;
    logic signed [31:0] sample;
    logic signed [31:0] setpoint;
  } ctrl_item_t;

  typedef struct {
    logic [15:0] drive;
    logic        clamped;
    logic        held;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [pid_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  pid_deadband_antiwindup DUT (.*);

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the registers and state.
  logic [31:0] kp, ki, kd;
  logic signed [31:0] int_lo, int_hi;
  logic [30:0] band;
  logic signed [31:0] integ, prev_meas;

  ctrl_item_t pending_items[$];
  drive_result_t expected_drives[$];
  int unsigned errors = 0;
  int unsigned accepted_in = 0;
  bit stall_long = 1'b0;

  // floor(g * v / 2^16), exact in wide arithmetic.
  function automatic logic signed [79:0] gain_mul(logic [31:0] g, logic signed [63:0] v);
    logic signed [99:0] p;
    p = $signed({1'b0, g}) * v;
    return 80'(p >>> 16);
  endfunction

  function automatic logic signed [31:0] sat_word(logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Work out the drive for one item and advance the controller state.
  function automatic drive_result_t predict_drive(ctrl_item_t it);
    drive_result_t r;
    logic signed [79:0] err, diff, dmeas, pterm, dterm, tent, acc, fin, aerr;
    logic [79:0] mag, q;
    logic [15:0] dt;
    dt = (it.step_time == 0) ? 16'd1 : it.step_time;
    if (it.setpoint <= 0) begin
      integ = 0;
      prev_meas = it.sample;
      r.drive = '0; r.clamped = 1'b0; r.held = 1'b1;
      return r;
    end
    err = sat_word(80'(it.setpoint) - 80'(it.sample));
    aerr = (err < 0) ? -err : err;
    if (aerr <= $signed({49'b0, band})) err = 0;
    diff = 80'(it.sample) - 80'(prev_meas);
    mag = ((diff < 0) ? -diff : diff) << 16;
    q = mag / dt;
    if (diff >= 0) dmeas = (q > 80'd2147483647) ? 80'sd2147483647 : $signed(q);
    else dmeas = (q > 80'd2147483648) ? -80'sd2147483648 : -$signed(q);
    pterm = gain_mul(kp, 64'(err));
    dterm = gain_mul(kd, 64'(dmeas));
    tent = pterm + gain_mul(ki, 64'(integ)) - dterm;
    r.held = (tent >= 65536 && err > 0) || (tent <= -65536 && err < 0);
    if (!r.held) begin
      acc = 80'(integ) + ((err * $signed({64'b0, dt})) >>> 16);
      if (acc > 80'(int_hi)) acc = 80'(int_hi);
      if (acc < 80'(int_lo)) acc = 80'(int_lo);
      integ = acc[31:0];
    end
    fin = pterm + gain_mul(ki, 64'(integ)) - dterm;
    r.clamped = 1'b0;
    if (fin > 65536) begin fin = 65536; r.clamped = 1'b1; end
    if (fin < -65536) begin fin = -65536; r.clamped = 1'b1; end
    prev_meas = it.sample;
    r.drive = 16'(fin >>> 2);
    return r;
  endfunction

  // Driver: present pending items with random gaps, predict on acceptance.
  int unsigned src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_drives.push_back(predict_drive(ctrl_item_t'(s_axis_tdata)));
        accepted_in <= accepted_in + 1;
        src_gap = $urandom_range(0, 5);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the item until taken
      end else if (src_gap > 0) begin
        src_gap = src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        s_axis_tdata <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  int unsigned sink_gap = 0;
  always @(posedge clk_i) begin
    drive_result_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_drives.size() == 0) begin
          $display("%0t: unexpected result drive=%h", $realtime, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          exp_r = expected_drives.pop_front();
          if (exp_r.drive !== m_axis_tdata || exp_r.clamped !== m_axis_tuser[0] ||
              exp_r.held !== m_axis_tuser[1]) begin
            $display({"%0t: mismatch expected drive=%h clamped=%b held=%b",
                      " actual drive=%h clamped=%b held=%b"},
                     $realtime, exp_r.drive, exp_r.clamped, exp_r.held,
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
            errors <= errors + 1;
          end
        end
        sink_gap = $urandom_range(0, 5);
      end
      if (stall_long) m_axis_tready <= 1'b0;
      else if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni ||
        stall_long ||
        (pending_items.size() == 0 && expected_drives.size() == 0 && !s_axis_tvalid))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("pid_deadband_antiwindup_tb failed");
      $finish;
    end
  end

  // Write one register in the design and the predictor.
  task automatic write_reg(logic [pid_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      pid_pkg::RegGainP: kp = val;
      pid_pkg::RegGainI: ki = val;
      pid_pkg::RegGainD: kd = val;
      pid_pkg::RegFloor: int_lo = val;
      pid_pkg::RegCeil:  int_hi = val;
      pid_pkg::RegBand:  band = val[30:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] lo, logic [31:0] hi, logic [31:0] b);
    write_reg(pid_pkg::RegGainP, p);
    write_reg(pid_pkg::RegGainI, i);
    write_reg(pid_pkg::RegGainD, d);
    write_reg(pid_pkg::RegFloor, lo);
    write_reg(pid_pkg::RegCeil, hi);
    write_reg(pid_pkg::RegBand, b);
  endtask

  // Wait for the block to drain, then let it settle.
  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_drives.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 131072))) - 65536;
      2: return 32'sh7FFFFFFF - $urandom_range(0, 3);
      3: return 32'sh80000000 + $urandom_range(0, 3);
      default: return $signed(32'($urandom_range(0, 400000))) - 200000;
    endcase
  endfunction

  // Mostly active items with small steps, some idle and full-range noise.
  task automatic queue_random(int unsigned n);
    ctrl_item_t it;
    repeat (n) begin
      it.setpoint = ($urandom_range(0, 9) == 0) ? -$signed(32'($urandom_range(0, 9))) :
                    ($urandom_range(0, 3) == 0 ? rand_val() :
                     $signed(32'($urandom_range(1, 200000))));
      it.sample = rand_val();
      it.step_time = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                     16'($urandom_range(1, 4000));
      pending_items.push_back(it);
    end
  endtask

  function automatic ctrl_item_t mk(logic [31:0] sp, logic [31:0] sm, logic [15:0] dt);
    ctrl_item_t it;
    it.setpoint = sp; it.sample = sm; it.step_time = dt;
    return it;
  endfunction

  initial begin
    kp = 0; ki = 0; kd = 0; int_lo = 0; int_hi = 0; band = 0;
    integ = 0; prev_meas = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: moderate gains, normal bounds.
    write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_0100,
              32'hFFFF_0000, 32'h0001_0000, 32'h0000_0400);
    pending_items.push_back(mk(32'h7FFFFFFF, 32'h80000000, 16'hFFFF));
    pending_items.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0001));
    pending_items.push_back(mk(32'h00000001, 32'h80000000, 16'h0000)); // zero step
    pending_items.push_back(mk(32'h00010000, 32'h0000FC00, 16'h0100)); // inside band
    pending_items.push_back(mk(32'h00010000, 32'h0000FBFF, 16'h0100)); // just outside
    pending_items.push_back(mk(32'h00000000, 32'h12345678, 16'h0100)); // idle at zero
    pending_items.push_back(mk(32'h80000000, 32'h7FFFFFFF, 16'hFFFF)); // idle negative
    pending_items.push_back(mk(32'h00080000, 32'h00000000, 16'h8000)); // saturate high
    pending_items.push_back(mk(32'h00080000, 32'h00000000, 16'h8000));
    pending_items.push_back(mk(32'h00000100, 32'h00100000, 16'h0010)); // saturate low
    pending_items.push_back(mk(32'h00000100, 32'h00100000, 16'h0010));
    pending_items.push_back(mk(32'h00020000, 32'hFFFF0000, 16'h0001)); // huge derivative
    drain();

    // Extreme gains and crossed integrator bounds.
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    pending_items.push_back(mk(32'h00010000, 32'h00000000, 16'h1000));
    pending_items.push_back(mk(32'h7FFFFFFF, 32'h80000000, 16'h1000));
    drain();
    write_all(32'h0000_0000, 32'h0000_4000, 32'h0000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    pending_items.push_back(mk(32'h00010000, 32'h00020000, 16'h1000));
    pending_items.push_back(mk(32'h00010000, 32'h00000000, 16'h1000));
    drain();

    // Random phases across several settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_all(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0004_0000),
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0002_0000),
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0000_4000),
                $signed(-32'sd1) * $signed(32'($urandom_range(0, 32'h0010_0000))),
                ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000),
                ($urandom_range(0, 7) == 0) ? {1'b0, 31'($urandom())} :
                                              $urandom_range(0, 32'h0000_2000));
      queue_random(RandItems / 6);
      if (ph == 2) begin
        // Hold off the receiver long enough that the input stalls.
        @(posedge clk_i);
        stall_long <= 1'b1;
        repeat (600) @(posedge clk_i);
        stall_long <= 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("pid_deadband_antiwindup_tb passed");
    end else begin
      $display("pid_deadband_antiwindup_tb failed");
    end
    $finish;
  end

endmodule
